// File: hdl/ght_pkg.sv
// shared constants, types and helper functions for the generational handle table
package ght_pkg;

   localparam int SLOTS    = 64;
   localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 3;
   localparam int TAG_W    = 32;
   localparam int HANDLE_W = 32;
   localparam int GEN_W    = 16;
   localparam int INDEX_W  = 16;
   localparam int COUNT_W  = 7;
   localparam int ENTRY_W  = GEN_W + TAG_W;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_ALLOC      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REGISTER   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKUP     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_UNREGISTER = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;
   localparam logic [MODE_W-1:0] MODE_LIST       = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_BUSY     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_NOOBJ    = 3'd5;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_DRAIN
   } fsm_state_type;

   // controller to datapath
   typedef struct packed {
      logic take;   // latch the request beat
      logic exec;   // single-slot operation, clear, or empty list
      logic scan;   // list walk, one slot per cycle
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic list_walk;  // request is a list of a non-empty table
      logic scan_end;   // walk is at the last slot
   } sts_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] idx;
   } free_type;

   // lowest slot whose valid bit is clear
   function automatic free_type first_free(input logic [SLOTS-1:0] valid);
      free_type res;
      res.found = 1'b0;
      res.idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid[i]) begin
            res.found = 1'b1;
            res.idx   = SLOT_W'(i);
         end
      end
      return res;
   endfunction

endpackage

// File: hdl/ght_ram.sv
// generic simple dual-port ram with registered read
module ght_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ght_ctrl.sv
// sequencing state machine for the handle table
module ght_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ght_pkg::sts_type  sts,
   output ght_pkg::cmd_type  cmd
);

   ght_pkg::fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ght_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ght_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.take = 1'b1;
               state_in = sts.list_walk ? ght_pkg::S_SCAN : ght_pkg::S_EXEC;
            end
         end
         ght_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ght_pkg::S_IDLE;
         end
         ght_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_end) begin
               state_in = ght_pkg::S_DRAIN;
            end
         end
         ght_pkg::S_DRAIN: begin
            // last read of the walk comes back this cycle
            state_in = ght_pkg::S_IDLE;
         end
         default: begin
            state_in = ght_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/ght_dpath.sv
// slot storage, operation logic and result registers of the handle table
module ght_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  ght_pkg::cmd_type                 cmd,
   output ght_pkg::sts_type                 sts,
   input  logic [ght_pkg::MODE_W-1:0]       req_mode,
   input  logic [ght_pkg::TAG_W-1:0]        req_object_tag,
   input  logic [ght_pkg::HANDLE_W-1:0]     req_handle_in,
   output logic                             rsp_valid,
   output logic [ght_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ght_pkg::HANDLE_W-1:0]     rsp_handle_out,
   output logic [ght_pkg::TAG_W-1:0]        rsp_tag_out,
   output logic [ght_pkg::COUNT_W-1:0]      rsp_entry_count,
   output logic                             rsp_item_valid,
   output logic                             rsp_last
);

   // latched request
   logic [ght_pkg::MODE_W-1:0]   mode_ff;
   logic [ght_pkg::TAG_W-1:0]    tag_ff;
   logic [ght_pkg::HANDLE_W-1:0] handle_ff;

   // table state
   logic [ght_pkg::SLOTS-1:0]    valid_ff, valid_in;
   logic [ght_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [ght_pkg::GEN_W-1:0]    next_gen_ff, next_gen_in;
   ght_pkg::free_type            free_ff;

   // list walk
   logic [ght_pkg::SLOT_W-1:0]   scan_ff;
   logic                         hit_ff;
   logic [ght_pkg::COUNT_W-1:0]  emit_ff;

   // result registers
   logic                         rsp_valid_ff;
   logic [ght_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [ght_pkg::HANDLE_W-1:0] rsp_handle_ff;
   logic [ght_pkg::TAG_W-1:0]    rsp_tag_ff;
   logic [ght_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic                         rsp_item_ff;
   logic                         rsp_last_ff;

   // operation results
   logic [ght_pkg::STATUS_W-1:0] res_status;
   logic [ght_pkg::HANDLE_W-1:0] res_handle;
   logic [ght_pkg::TAG_W-1:0]    res_tag;
   logic                         res_item;

   // ram port
   logic                         wr_en;
   logic [ght_pkg::SLOT_W-1:0]   wr_addr;
   logic [ght_pkg::ENTRY_W-1:0]  wr_data;
   logic [ght_pkg::SLOT_W-1:0]   rd_addr;
   logic [ght_pkg::ENTRY_W-1:0]  rd_data;
   logic [ght_pkg::GEN_W-1:0]    rd_gen;
   logic [ght_pkg::TAG_W-1:0]    rd_tag;

   // request decode
   logic [ght_pkg::INDEX_W-1:0]  req_idx;
   logic [ght_pkg::GEN_W-1:0]    req_gen;
   logic [ght_pkg::SLOT_W-1:0]   idx;
   logic                         in_range;
   logic                         slot_busy;
   logic                         tag_zero;

   assign req_idx   = handle_ff[ght_pkg::INDEX_W-1:0];
   assign req_gen   = handle_ff[ght_pkg::HANDLE_W-1 -: ght_pkg::GEN_W];
   assign idx       = req_idx[ght_pkg::SLOT_W-1:0];
   assign in_range  = (req_idx < ght_pkg::INDEX_W'(ght_pkg::SLOTS));
   assign slot_busy = in_range && valid_ff[idx];
   assign tag_zero  = (tag_ff == '0);
   assign rd_gen    = rd_data[ght_pkg::ENTRY_W-1 -: ght_pkg::GEN_W];
   assign rd_tag    = rd_data[ght_pkg::TAG_W-1:0];

   // read at the request slot while idle, at the walk position while listing
   assign rd_addr = cmd.scan ? scan_ff : req_handle_in[ght_pkg::SLOT_W-1:0];

   ght_ram #(
      .WIDTH (ght_pkg::ENTRY_W),
      .DEPTH (ght_pkg::SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sts.list_walk = (req_mode == ght_pkg::MODE_LIST) && (count_ff != '0);
   assign sts.scan_end  = (scan_ff == ght_pkg::SLOT_W'(ght_pkg::SLOTS - 1));

   always_comb begin
      valid_in    = valid_ff;
      count_in    = count_ff;
      next_gen_in = next_gen_ff;
      wr_en       = 1'b0;
      wr_addr     = idx;
      wr_data     = {req_gen, tag_ff};
      res_status  = ght_pkg::STAT_OK;
      res_handle  = handle_ff;
      res_tag     = '0;
      res_item    = 1'b0;
      if (cmd.exec) begin
         case (mode_ff)
            ght_pkg::MODE_ALLOC: begin
               if (tag_zero) begin
                  res_status = ght_pkg::STAT_NOOBJ;
               end else if (!free_ff.found) begin
                  res_status = ght_pkg::STAT_FULL;
               end else begin
                  wr_en                 = 1'b1;
                  wr_addr               = free_ff.idx;
                  wr_data               = {next_gen_ff, tag_ff};
                  valid_in[free_ff.idx] = 1'b1;
                  count_in              = count_ff + 1'b1;
                  next_gen_in           = next_gen_ff + 1'b1;
                  res_handle            = {next_gen_ff, ght_pkg::INDEX_W'(free_ff.idx)};
               end
            end
            ght_pkg::MODE_REGISTER: begin
               if (tag_zero) begin
                  res_status = ght_pkg::STAT_NOOBJ;
               end else if (!in_range) begin
                  res_status = ght_pkg::STAT_RANGE;
               end else if (slot_busy) begin
                  res_status = ght_pkg::STAT_BUSY;
               end else begin
                  wr_en         = 1'b1;
                  valid_in[idx] = 1'b1;
                  count_in      = count_ff + 1'b1;
               end
            end
            ght_pkg::MODE_LOOKUP: begin
               if (!in_range) begin
                  res_status = ght_pkg::STAT_RANGE;
               end else if (slot_busy && (rd_gen == req_gen)) begin
                  res_tag  = rd_tag;
                  res_item = 1'b1;
               end else begin
                  res_status = ght_pkg::STAT_NOTFOUND;
               end
            end
            ght_pkg::MODE_UNREGISTER: begin
               if (tag_zero) begin
                  res_status = ght_pkg::STAT_NOOBJ;
               end else if (!in_range) begin
                  res_status = ght_pkg::STAT_RANGE;
               end else if (slot_busy && (rd_tag == tag_ff)) begin
                  valid_in[idx] = 1'b0;
                  count_in      = count_ff - 1'b1;
               end else begin
                  res_status = ght_pkg::STAT_NOTFOUND;
               end
            end
            ght_pkg::MODE_CLEAR: begin
               valid_in = '0;
               count_in = '0;
            end
            ght_pkg::MODE_LIST: begin
               // empty table: single closing result, defaults apply
            end
            default: begin
               res_status = ght_pkg::STAT_NOTFOUND;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         next_gen_ff  <= '0;
         free_ff      <= '0;
         scan_ff      <= '0;
         hit_ff       <= 1'b0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         next_gen_ff  <= next_gen_in;
         free_ff      <= ght_pkg::first_free(valid_ff);
         hit_ff       <= cmd.scan && valid_ff[scan_ff];
         rsp_valid_ff <= cmd.exec || hit_ff;
         if (cmd.take) begin
            scan_ff <= '0;
            emit_ff <= '0;
         end else begin
            if (cmd.scan) begin
               scan_ff <= scan_ff + 1'b1;
            end
            if (hit_ff) begin
               emit_ff <= emit_ff + 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         mode_ff   <= req_mode;
         tag_ff    <= req_object_tag;
         handle_ff <= req_handle_in;
      end
      if (cmd.exec) begin
         rsp_status_ff <= res_status;
         rsp_handle_ff <= res_handle;
         rsp_tag_ff    <= res_tag;
         rsp_count_ff  <= count_in;
         rsp_item_ff   <= res_item;
         rsp_last_ff   <= 1'b1;
      end else if (hit_ff) begin
         rsp_status_ff <= ght_pkg::STAT_OK;
         rsp_handle_ff <= handle_ff;
         rsp_tag_ff    <= rd_tag;
         rsp_count_ff  <= count_ff;
         rsp_item_ff   <= 1'b1;
         rsp_last_ff   <= ((emit_ff + 1'b1) == count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_handle_out  = rsp_handle_ff;
   assign rsp_tag_out     = rsp_tag_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_item_valid  = rsp_item_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// File: hdl/generational_handle_table_core.sv
// top level of the generational handle table: controller, datapath and checks
//
// usage
//  - a request beat (req_mode, req_object_tag, req_handle_in) is taken at a clock
//    edge where start is high and busy is low; busy stays high while it is worked on
//  - each result beat sits on the rsp_ ports for exactly one cycle with rsp_valid
//    high; rsp_last marks the final beat of a request. there is no back-pressure
//  - allocate, register, lookup, unregister, clear and unknown modes: one result
//    beat, registered at the end of the execute state; the next request can be
//    taken in the cycle the result shows
//  - list of a non-empty table walks every slot once, one slot read per cycle from
//    the single read port of the slot ram; result beats trail the walk through the
//    ram read and hit registers and then the result registers; an empty table
//    gives one closing beat like the single-slot operations
//  - the lowest free slot is kept in a register refreshed every cycle from the
//    valid bits, so allocate needs no search in its execute cycle
//  - reset clears valid bits, entry count, generation counter and the
//    controller; slot tags and generations are only read behind a valid bit, so
//    the ram needs no clearing pass and the block is ready right after reset
module generational_handle_table_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ght_pkg::MODE_W-1:0]       req_mode,
   input  logic [ght_pkg::TAG_W-1:0]        req_object_tag,
   input  logic [ght_pkg::HANDLE_W-1:0]     req_handle_in,
   output logic                             rsp_valid,
   output logic [ght_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ght_pkg::HANDLE_W-1:0]     rsp_handle_out,
   output logic [ght_pkg::TAG_W-1:0]        rsp_tag_out,
   output logic [ght_pkg::COUNT_W-1:0]      rsp_entry_count,
   output logic                             rsp_item_valid,
   output logic                             rsp_last
);

   ght_pkg::cmd_type cmd;
   ght_pkg::sts_type sts;

   // sequencer: idle, execute, list walk, walk drain
   ght_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // slot state, operation decode and result registers
   ght_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_mode),
      .req_object_tag  (req_object_tag),
      .req_handle_in   (req_handle_in),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_handle_out  (rsp_handle_out),
      .rsp_tag_out     (rsp_tag_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_item_valid  (rsp_item_valid),
      .rsp_last        (rsp_last)
   );

   // an accepted beat always makes the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // a result that shows while idle closes its request
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !busy) |-> rsp_last)
      else $error("result beat shown while idle without last");

   // a carried tag only comes with a successful status
   a_item_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item_valid) |-> (rsp_status == ght_pkg::STAT_OK))
      else $error("item beat with failing status");

   // entry count never exceeds the table size
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= ght_pkg::COUNT_W'(ght_pkg::SLOTS)))
      else $error("entry count above table size");

endmodule

// File: tb/sv/ght_reply_checker.sv
// reply checker for the handle table: predicts every reply beat and compares it
module ght_reply_checker
   import ght_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [TAG_W-1:0]    req_object_tag,
   input  logic [HANDLE_W-1:0] req_handle_in,
   input  logic                rsp_valid,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [HANDLE_W-1:0] rsp_handle_out,
   input  logic [TAG_W-1:0]    rsp_tag_out,
   input  logic [COUNT_W-1:0]  rsp_entry_count,
   input  logic                rsp_item_valid,
   input  logic                rsp_last,
   output int                  fault_count,
   output int                  owed_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle;
      logic [TAG_W-1:0]    tag;
      logic [COUNT_W-1:0]  count;
      logic                item;
      logic                last;
   } reply_beat_type;

   reply_beat_type owed_replies[$];

   // predicted table contents
   logic [SLOTS-1:0]   live;
   logic [TAG_W-1:0]   live_tag[SLOTS];
   logic [GEN_W-1:0]   live_gen[SLOTS];
   logic [COUNT_W-1:0] live_count;
   logic [GEN_W-1:0]   gen_next;

   function automatic void owe(input logic [STATUS_W-1:0] status,
                               input logic [HANDLE_W-1:0] handle,
                               input logic [TAG_W-1:0] tag,
                               input logic item, input logic last);
      reply_beat_type beat;
      beat.status = status;
      beat.handle = handle;
      beat.tag    = tag;
      beat.count  = live_count;
      beat.item   = item;
      beat.last   = last;
      owed_replies.push_back(beat);
   endfunction

   function automatic void predict_table_op(input logic [MODE_W-1:0] mode,
                                            input logic [TAG_W-1:0] tag,
                                            input logic [HANDLE_W-1:0] handle);
      logic [INDEX_W-1:0] idx;
      logic [SLOT_W-1:0]  sidx;
      logic [GEN_W-1:0]   gen;
      logic [GEN_W-1:0]   stamp;
      int                 slot;
      int                 listed;
      idx  = handle[INDEX_W-1:0];
      sidx = idx[SLOT_W-1:0];
      gen  = handle[HANDLE_W-1:INDEX_W];
      case (mode)
         MODE_ALLOC: begin
            slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (!live[i]) slot = i;
            if (tag == '0) begin
               owe(STAT_NOOBJ, handle, '0, 1'b0, 1'b1);
            end else if (slot < 0) begin
               owe(STAT_FULL, handle, '0, 1'b0, 1'b1);
            end else begin
               stamp          = gen_next;
               gen_next       = gen_next + 1'b1;
               live[slot]     = 1'b1;
               live_tag[slot] = tag;
               live_gen[slot] = stamp;
               live_count     = live_count + 1'b1;
               owe(STAT_OK, {stamp, INDEX_W'(slot)}, '0, 1'b0, 1'b1);
            end
         end
         MODE_REGISTER: begin
            if (tag == '0) begin
               owe(STAT_NOOBJ, handle, '0, 1'b0, 1'b1);
            end else if (idx >= SLOTS) begin
               owe(STAT_RANGE, handle, '0, 1'b0, 1'b1);
            end else if (live[sidx]) begin
               owe(STAT_BUSY, handle, '0, 1'b0, 1'b1);
            end else begin
               live[sidx]     = 1'b1;
               live_tag[sidx] = tag;
               live_gen[sidx] = gen;
               live_count     = live_count + 1'b1;
               owe(STAT_OK, handle, '0, 1'b0, 1'b1);
            end
         end
         MODE_LOOKUP: begin
            if (idx >= SLOTS) begin
               owe(STAT_RANGE, handle, '0, 1'b0, 1'b1);
            end else if (live[sidx] && live_gen[sidx] == gen) begin
               owe(STAT_OK, handle, live_tag[sidx], 1'b1, 1'b1);
            end else begin
               owe(STAT_NOTFOUND, handle, '0, 1'b0, 1'b1);
            end
         end
         MODE_UNREGISTER: begin
            // only the tag decides, the generation is ignored
            if (tag == '0) begin
               owe(STAT_NOOBJ, handle, '0, 1'b0, 1'b1);
            end else if (idx >= SLOTS) begin
               owe(STAT_RANGE, handle, '0, 1'b0, 1'b1);
            end else if (live[sidx] && live_tag[sidx] == tag) begin
               live[sidx] = 1'b0;
               live_count = live_count - 1'b1;
               owe(STAT_OK, handle, '0, 1'b0, 1'b1);
            end else begin
               owe(STAT_NOTFOUND, handle, '0, 1'b0, 1'b1);
            end
         end
         MODE_CLEAR: begin
            live       = '0;
            live_count = '0;
            owe(STAT_OK, handle, '0, 1'b0, 1'b1);
         end
         MODE_LIST: begin
            listed = 0;
            for (int i = 0; i < SLOTS; i++) begin
               if (live[i]) begin
                  listed++;
                  owe(STAT_OK, handle, live_tag[i], 1'b1, listed == int'(live_count));
               end
            end
            if (listed == 0) owe(STAT_OK, handle, '0, 1'b0, 1'b1);
         end
         default: owe(STAT_NOTFOUND, handle, '0, 1'b0, 1'b1);
      endcase
   endfunction

   function automatic int check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      reply_beat_type want;
      int             bad;
      bad = 0;
      if (reset) begin
         live       = '0;
         live_count = '0;
         gen_next   = '0;
         owed_replies.delete();
      end else begin
         // a reply in this cycle always belongs to an earlier request beat
         if (rsp_valid !== 1'b0) begin
            if (owed_replies.size() == 0) begin
               $error("reply beat with none expected: status %0d handle 0x%0h tag 0x%0h",
                      rsp_status, rsp_handle_out, rsp_tag_out);
               bad = 1;
            end else begin
               want = owed_replies.pop_front();
               bad  = check_field("status", 32'(want.status), 32'(rsp_status))
                    + check_field("handle_out", want.handle, rsp_handle_out)
                    + check_field("tag_out", want.tag, rsp_tag_out)
                    + check_field("entry_count", 32'(want.count), 32'(rsp_entry_count))
                    + check_field("item_valid", 32'(want.item), 32'(rsp_item_valid))
                    + check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            predict_table_op(req_mode, req_object_tag, req_handle_in);
      end
      owed_count  <= owed_replies.size();
      fault_count <= fault_count + bad;
   end

endmodule

// File: tb/sv/tb_generational_handle_table_core.sv
// testbench top for the handle table core: clock, reset, request stimulus and verdict
module tb_generational_handle_table_core;
   timeunit 1ns;
   timeprecision 1ps;
   import ght_pkg::*;

   // modes the block does not define, answered with not found
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   localparam int RANDOM_ITEMS = 88;
   // every slot once, then one more allocate after the table has been full
   localparam int SWEEP_ALLOCS = SLOTS + 1;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 1000000;

   // request mixes for the random part
   typedef enum {PH_FILL, PH_MIXED, PH_DRAIN} mix_type;

   logic                clock;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic                busy;
   logic [MODE_W-1:0]   req_mode       = '0;
   logic [TAG_W-1:0]    req_object_tag = '0;
   logic [HANDLE_W-1:0] req_handle_in  = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [HANDLE_W-1:0] rsp_handle_out;
   logic [TAG_W-1:0]    rsp_tag_out;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic                rsp_item_valid;
   logic                rsp_last;
   int                  fault_count;
   int                  owed_count;

   // random idles between request beats, switched off for quiet stretches
   bit                  gaps_on = 1'b1;

   // what the stimulus believes is stored, used only to aim requests at live slots
   bit   [SLOTS-1:0]    in_use = '0;
   logic [TAG_W-1:0]    use_tag[SLOTS];
   logic [GEN_W-1:0]    use_gen[SLOTS];
   int                  in_use_count = 0;
   logic [GEN_W-1:0]    gen_ctr = '0;

   generational_handle_table_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_object_tag  (req_object_tag),
      .req_handle_in   (req_handle_in),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_handle_out  (rsp_handle_out),
      .rsp_tag_out     (rsp_tag_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_item_valid  (rsp_item_valid),
      .rsp_last        (rsp_last)
   );

   ght_reply_checker reply_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_object_tag  (req_object_tag),
      .req_handle_in   (req_handle_in),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_handle_out  (rsp_handle_out),
      .rsp_tag_out     (rsp_tag_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_item_valid  (rsp_item_valid),
      .rsp_last        (rsp_last),
      .fault_count     (fault_count),
      .owed_count      (owed_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog: a hung handshake or a missing reply ends the run here
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // keep the stimulus view of the table in step with each accepted beat
   function automatic void track_table(input logic [MODE_W-1:0] mode,
                                       input logic [TAG_W-1:0] tag,
                                       input logic [HANDLE_W-1:0] handle);
      int idx;
      int slot;
      idx = int'(handle[INDEX_W-1:0]);
      case (mode)
         MODE_ALLOC: begin
            slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (!in_use[i]) slot = i;
            if (tag != '0 && slot >= 0) begin
               in_use[slot]  = 1'b1;
               use_tag[slot] = tag;
               use_gen[slot] = gen_ctr;
               gen_ctr       = gen_ctr + 1'b1;
               in_use_count++;
            end
         end
         MODE_REGISTER: begin
            if (tag != '0 && idx < SLOTS && !in_use[idx]) begin
               in_use[idx]  = 1'b1;
               use_tag[idx] = tag;
               use_gen[idx] = handle[HANDLE_W-1:INDEX_W];
               in_use_count++;
            end
         end
         MODE_UNREGISTER: begin
            if (tag != '0 && idx < SLOTS && in_use[idx] && use_tag[idx] == tag) begin
               in_use[idx] = 1'b0;
               in_use_count--;
            end
         end
         MODE_CLEAR: begin
            in_use       = '0;
            in_use_count = 0;
         end
         default: ;
      endcase
   endfunction

   // a live slot picked at random, or -1 on an empty table
   function automatic int pick_held();
      int s;
      s = $urandom_range(0, SLOTS - 1);
      for (int k = 0; k < SLOTS; k++)
         if (in_use[(s + k) % SLOTS]) return (s + k) % SLOTS;
      return -1;
   endfunction

   // mostly random tags, with the all-ones tag and, if allowed, the no-object tag
   function automatic logic [TAG_W-1:0] pick_tag(input bit allow_zero);
      int                 r;
      logic [TAG_W-1:0]   t;
      r = $urandom_range(0, 99);
      if (allow_zero && r < 5) return '0;
      if (r < 8) return '1;
      t = $urandom;
      if (t == '0) t = 1;
      return t;
   endfunction

   // present one request beat and hold it until the block takes it
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [TAG_W-1:0] tag,
                               input logic [HANDLE_W-1:0] handle);
      req_mode       <= mode;
      req_object_tag <= tag;
      req_handle_in  <= handle;
      start          <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      track_table(mode, tag, handle);
      // idle about 37 beats in a hundred, with junk on the request ports
      if (gaps_on && $urandom_range(0, 99) < 37) begin
         start          <= 1'b0;
         req_mode       <= $urandom;
         req_object_tag <= $urandom;
         req_handle_in  <= $urandom;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // one random request, weighted by the current mix
   task automatic send_random(input mix_type mix);
      int                  r;
      int                  slot;
      int                  alloc_w;
      int                  reg_w;
      bit                  pick_unreg;
      logic [MODE_W-1:0]   mode;
      logic [TAG_W-1:0]    tag;
      logic [HANDLE_W-1:0] handle;
      case (mix)
         PH_FILL:  begin alloc_w = 45; reg_w = 20; end
         PH_DRAIN: begin alloc_w = 5;  reg_w = 5;  end
         default:  begin alloc_w = 20; reg_w = 15; end
      endcase
      if (mix == PH_DRAIN) pick_unreg = ($urandom_range(0, 99) < 70);
      else                 pick_unreg = ($urandom_range(0, 1) != 0);
      r      = $urandom_range(0, 99);
      tag    = pick_tag(1'b1);
      handle = $urandom;
      slot   = pick_held();
      if (r < 2) begin
         mode = MODE_CLEAR;
      end else if (r < 4) begin
         mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_HI : MODE_SPARE_LO;
      end else if (r < 10) begin
         mode = MODE_LIST;
      end else if (r < 10 + alloc_w) begin
         mode = MODE_ALLOC;
      end else if (r < 10 + alloc_w + reg_w) begin
         // mostly in range, some past the last slot up to the top index
         mode = MODE_REGISTER;
         if ($urandom_range(0, 99) < 85)
            handle[INDEX_W-1:0] = INDEX_W'($urandom_range(0, SLOTS - 1));
         else
            handle[INDEX_W-1:0] = INDEX_W'($urandom_range(SLOTS, 16'hffff));
      end else if (pick_unreg) begin
         // mostly a matching tag at a live slot, generation left random on purpose
         mode = MODE_UNREGISTER;
         if (slot >= 0 && $urandom_range(0, 99) < 65) begin
            tag                 = use_tag[slot];
            handle[INDEX_W-1:0] = INDEX_W'(slot);
         end else if ($urandom_range(0, 1) != 0) begin
            handle[INDEX_W-1:0] = INDEX_W'($urandom_range(0, SLOTS - 1));
         end
      end else begin
         // hits on live handles, stale generations, and stray handles
         mode = MODE_LOOKUP;
         if (slot >= 0 && $urandom_range(0, 99) < 65) begin
            handle = {use_gen[slot], INDEX_W'(slot)};
            if ($urandom_range(0, 99) < 25)
               handle[HANDLE_W-1:INDEX_W] ^= GEN_W'($urandom_range(1, 16'hffff));
         end else if ($urandom_range(0, 1) != 0) begin
            handle[INDEX_W-1:0] = INDEX_W'($urandom_range(0, SLOTS - 1));
         end
      end
      send_request(mode, tag, handle);
   endtask

   initial begin
      int      sweep_done;
      bit      full_seen;
      mix_type mix;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, zero tags, range and busy errors, hits and misses
      send_request(MODE_LIST,       32'h0000_0000, 32'h0000_0000);  // empty list
      send_request(MODE_LOOKUP,     32'h0000_0000, 32'h0000_0000);  // free slot
      send_request(MODE_ALLOC,      32'h0000_0000, 32'h1111_2222);  // no object
      send_request(MODE_ALLOC,      32'hffff_ffff, 32'hffff_ffff);  // slot 0 gen 0
      send_request(MODE_ALLOC,      32'h0000_0001, 32'h0000_0000);  // slot 1 gen 1
      send_request(MODE_REGISTER,   32'ha5a5_a5a5, {16'hffff, 16'd63});
      send_request(MODE_REGISTER,   32'h5a5a_5a5a, {16'hffff, 16'd63});  // busy
      send_request(MODE_REGISTER,   32'h1234_5678, {16'h0000, 16'd64});  // first bad index
      send_request(MODE_REGISTER,   32'h1234_5678, 32'hffff_ffff);      // top index
      send_request(MODE_REGISTER,   32'h0000_0000, {16'h0000, 16'd10});  // no object
      send_request(MODE_LOOKUP,     32'h0000_0000, {16'h0000, 16'd0});   // hit
      send_request(MODE_LOOKUP,     32'hffff_ffff, {16'hffff, 16'd63});  // hit
      send_request(MODE_LOOKUP,     32'h0000_0000, {16'h0005, 16'd0});   // stale gen
      send_request(MODE_LOOKUP,     32'h0000_0000, {16'h0000, 16'hffff}); // out of range
      send_request(MODE_LOOKUP,     32'h0000_0000, {16'h0000, 16'd10});  // free slot
      send_request(MODE_UNREGISTER, 32'h0000_0002, {16'h0001, 16'd1});   // other tag
      send_request(MODE_UNREGISTER, 32'h0000_0000, {16'h0001, 16'd1});   // no object
      send_request(MODE_UNREGISTER, 32'h0000_0001, {16'h0000, 16'd64});  // out of range
      send_request(MODE_UNREGISTER, 32'h0000_0001, {16'h1234, 16'd1});   // gen ignored
      send_request(MODE_UNREGISTER, 32'h0000_0001, {16'h0001, 16'd1});   // already free
      send_request(MODE_LIST,       32'hdead_beef, 32'hcafe_f00d);       // two entries
      send_request(MODE_SPARE_LO,   32'h0000_0007, 32'h8000_0001);
      send_request(MODE_SPARE_HI,   32'hffff_ffff, 32'hffff_ffff);
      send_request(MODE_CLEAR,      32'h0000_0000, 32'h7fff_8000);
      send_request(MODE_LIST,       32'h0000_0000, 32'h0001_0001);       // empty again

      // back-to-back allocate sweep: every slot taken, table full once and a
      // full list; this is also the long stretch without idles
      gaps_on    = 1'b0;
      sweep_done = 0;
      full_seen  = 1'b0;
      while (sweep_done < SWEEP_ALLOCS) begin
         if (in_use_count == SLOTS) begin
            if (!full_seen) begin
               send_request(MODE_ALLOC, pick_tag(1'b0), $urandom);   // table full
               send_request(MODE_LIST, pick_tag(1'b1), $urandom);    // every slot
               full_seen = 1'b1;
            end
            send_request(MODE_CLEAR, pick_tag(1'b1), $urandom);
         end else begin
            send_request(MODE_ALLOC, pick_tag(1'b0), $urandom);
            sweep_done++;
         end
      end
      send_request(MODE_CLEAR, pick_tag(1'b1), $urandom);

      // random part: fill, mix, drain (without idles), mix
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         gaps_on = !(n >= 44 && n < 66);
         if (n < 22)       mix = PH_FILL;
         else if (n < 44)  mix = PH_MIXED;
         else if (n < 66)  mix = PH_DRAIN;
         else              mix = PH_MIXED;
         send_random(mix);
      end

      // let every owed reply beat arrive, then keep watching for stray beats
      start <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: filelist.f
hdl/ght_pkg.sv
hdl/ght_ram.sv
hdl/ght_ctrl.sv
hdl/ght_dpath.sv
hdl/generational_handle_table_core.sv
tb/sv/ght_reply_checker.sv
tb/sv/tb_generational_handle_table_core.sv
